// ===== rtl/core/llwp_pkg.sv =====
package llwp_pkg;

    // Pool geometry.
    localparam int POOL_SIZE  = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int ACT_W      = $clog2(POOL_SIZE + 1);

    // Fixed field widths of the channels.
    localparam int OP_W       = 1;
    localparam int RIDX_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int LOAD_W     = 16;

    // Configuration register widths and indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAXW_W     = 5;
    localparam int LOWM_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORKERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK    = 1'd1;
    localparam logic [MAXW_W-1:0]    MAXW_RESET      = 5'd16;
    localparam logic [LOWM_W-1:0]    LOWM_RESET      = 16'd0;

    // Request codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NEW       = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [RIDX_W-1:0] release_index;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [RIDX_W-1:0] chosen_index;
        logic [LOAD_W-1:0] load_after;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_step;
        logic do_release;
        logic do_alloc;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic pool_empty;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/llwp_ctrl.sv =====
module llwp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  llwp_pkg::t_stat i_stat,
    output llwp_pkg::t_cmd  o_cmd
);
    import llwp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_REL      = 5'b01000,
        S_DEC      = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_release) begin
                    n_state = S_REL;
                end else if (i_stat.pool_empty) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DEC;
                end
            end
            S_REL: begin
                if (i_stat.out_free) begin
                    o_cmd.do_release = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DEC: begin
                if (i_stat.out_free) begin
                    o_cmd.do_alloc = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/llwp_dp.sv =====
module llwp_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  llwp_pkg::t_in_item                    i_in_item,
    input  logic                                  i_cfg_we,
    input  logic [llwp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [llwp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  llwp_pkg::t_cmd                        i_cmd,
    output llwp_pkg::t_stat                       o_stat,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output llwp_pkg::t_out_item                   o_out_item
);
    import llwp_pkg::*;

    localparam int     EFF_W   = (ACT_W > MAXW_W) ? ACT_W : MAXW_W;
    localparam int     CMP_W   = (COUNT_BITS > LOWM_W) ? COUNT_BITS : LOWM_W;
    localparam t_count CNT_MAX = '1;

    // Configuration and pool state.
    logic [MAXW_W-1:0] r_max_workers;
    logic [LOWM_W-1:0] r_low_mark;
    logic [ACT_W-1:0]  r_active;
    t_count            r_counts [POOL_SIZE];

    // Captured request and scan state.
    logic [OP_W-1:0]   r_op;
    logic [RIDX_W-1:0] r_ri;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_best;
    t_count            r_min;

    // Output stage.
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              is_release;
    logic              pool_empty;
    logic [IDX_W-1:0]  rd_addr;
    t_count            rd_data;
    logic              found;
    t_count            dec_val;
    t_count            inc_val;
    logic [EFF_W-1:0]  eff_max;
    logic              at_max;
    logic              below_mark;
    logic              reuse;
    logic              can_grow;
    logic              out_free;
    logic              load_out;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_count            wr_data;
    t_out_item         n_out_item;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_workers <= MAXW_RESET;
            r_low_mark    <= LOWM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_WORKERS: r_max_workers <= i_cfg_data[MAXW_W-1:0];
                CFG_LOW_MARK:    r_low_mark    <= i_cfg_data[LOWM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Status decode and the single read port of the load counters.
    assign is_release = (r_op == OP_RELEASE);
    assign pool_empty = (r_active == '0);
    assign rd_addr    = is_release ? IDX_W'(r_ri) : r_idx;
    assign rd_data    = r_counts[rd_addr];
    assign found      = (ACT_W'(r_ri) < r_active);
    assign dec_val    = (rd_data == '0) ? rd_data : rd_data - t_count'(1);
    assign inc_val    = (r_min == CNT_MAX) ? r_min : r_min + t_count'(1);

    // Effective pool limit, clamped to one through the pool size.
    always_comb begin
        if (r_max_workers == '0) begin
            eff_max = EFF_W'(1);
        end else if (EFF_W'(r_max_workers) > EFF_W'(POOL_SIZE)) begin
            eff_max = EFF_W'(POOL_SIZE);
        end else begin
            eff_max = EFF_W'(r_max_workers);
        end
    end

    assign at_max     = (EFF_W'(r_active) >= eff_max);
    assign below_mark = (CMP_W'(r_min) < CMP_W'(r_low_mark));
    assign reuse      = !pool_empty && (at_max || below_mark);
    assign can_grow   = (r_active < ACT_W'(POOL_SIZE));
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = i_cmd.do_release || i_cmd.do_alloc;

    assign o_stat.is_release = is_release;
    assign o_stat.pool_empty = pool_empty;
    assign o_stat.scan_last  = ((ACT_W'(r_idx) + ACT_W'(1)) == r_active);
    assign o_stat.out_free   = out_free;

    // Counter write and result selection.
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_best;
        wr_data    = inc_val;
        n_out_item = '{status: ST_NOT_FOUND, chosen_index: '0, load_after: '0};
        if (i_cmd.do_release) begin
            if (found) begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(r_ri);
                wr_data    = dec_val;
                n_out_item = '{status: ST_OK, chosen_index: r_ri,
                               load_after: LOAD_W'(dec_val)};
            end else begin
                n_out_item = '{status: ST_NOT_FOUND, chosen_index: r_ri,
                               load_after: '0};
            end
        end else if (i_cmd.do_alloc) begin
            if (reuse) begin
                wr_en      = 1'b1;
                wr_addr    = r_best;
                wr_data    = inc_val;
                n_out_item = '{status: ST_OK, chosen_index: RIDX_W'(r_best),
                               load_after: LOAD_W'(inc_val)};
            end else if (can_grow) begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(r_active);
                wr_data    = t_count'(1);
                n_out_item = '{status: ST_NEW, chosen_index: RIDX_W'(r_active),
                               load_after: LOAD_W'(1)};
            end
        end
    end

    // Load counters: entries are written before they are ever read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_counts[wr_addr] <= wr_data;
        end
    end

    // Active worker count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.do_alloc && !reuse && can_grow) begin
            r_active <= r_active + ACT_W'(1);
        end
    end

    // Request capture and minimum scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in_item.opcode;
            r_ri <= i_in_item.release_index;
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_idx == '0 || rd_data < r_min) begin
                r_min  <= rd_data;
                r_best <= r_idx;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Output register holds one result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/least_loaded_worker_pool_unit.sv =====
// Least-loaded worker pool. Each request beat produces exactly one result beat.
// A release passes the dispatch and release states before the next request is taken.
// An allocate passes the dispatch state, a scan over the N active workers (0 to 16)
// and the decision state; the load counters are scanned through a single read port,
// one counter per cycle. A new request can be accepted while the
// previous result is still waiting in the output register. The next result is held
// back only while that register is still occupied. Configuration writes
// (max_workers at index 0, low_mark at index 1) take effect at once and must be
// issued only while the block is idle.
module least_loaded_worker_pool_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  llwp_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output llwp_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_we,
    input  logic [llwp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llwp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import llwp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    llwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Load counters, scan and result stage.
    llwp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // One request at a time: an accepted beat closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    // A result is only written into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.do_release || cmd.do_alloc) |-> stat.out_free)
        else $error("result written over a pending result");

    // A newly activated worker always starts with a load of one.
    a_new_load_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_NEW) |-> (o_out_item.load_after == 16'd1))
        else $error("new worker reported with a load other than one");

    // A not-found result carries no load.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_NOT_FOUND) |->
        (o_out_item.load_after == 16'd0))
        else $error("not-found result with a nonzero load");

endmodule
